FILE: rtl/core/tnb_pkg.sv
// shared types, constants and helpers of the tanh neuron backprop unit
// builds the tanh lookup table at elaboration; no dependencies
package tnb_pkg;

	localparam int FRAC_BITS = 12;
	localparam int TANH_DEPTH = 256;
	localparam int TAB_AW = $clog2(TANH_DEPTH);
	localparam int TAB_W = FRAC_BITS + 1;
	localparam int ACC_W = 40;
	localparam int MUL_AW = 41;
	localparam int MUL_BW = 18;
	localparam int PROD_W = MUL_AW + MUL_BW;
	localparam logic [63:0] Q30_ONE = 64'd1 << 30;
	localparam logic [63:0] Q30_EXP_M1 = 64'd395007543;

	typedef enum logic [1:0] {
		FUNC_FWD   = 2'd0,
		FUNC_OGRAD = 2'd1,
		FUNC_HGRAD = 2'd2,
		FUNC_UPD   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		REG_LEARNING_RATE = 2'd0,
		REG_MOMENTUM      = 2'd1
	} reg_idx_t;

	typedef enum logic [4:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_MUL_AW,
		CMD_MUL_WG,
		CMD_MUL_AG,
		CMD_ACC,
		CMD_NET,
		CMD_SQ,
		CMD_DER,
		CMD_MUL_TD,
		CMD_MUL_AD,
		CMD_MLR,
		CMD_MOM,
		CMD_SUM,
		CMD_OUT_FWD,
		CMD_OUT_G1,
		CMD_OUT_G2,
		CMD_OUT_UPD
	} cmd_t;

	typedef struct packed {
		cmd_t cmd;
	} ctl_t;

	typedef struct packed {
		logic out_free;
	} stat_t;

	typedef logic [TAB_W-1:0] tab_t [TANH_DEPTH];

	function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
		logic signed [15:0] r;
		if (v > 64'sd32767)
			r = 16'sh7fff;
		else if (v < -64'sd32768)
			r = 16'sh8000;
		else
			r = v[15:0];
		return r;
	endfunction

	// shift-subtract division, elaboration only
	function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		logic [64:0] rem;
		q = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], n[b]};
			if (rem >= {1'b0, d}) begin
				rem = rem - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic tab_t build_tanh();
		tab_t tab;
		logic [63:0] xr, y, f, fq, t, e, n, num, den;
		logic signed [63:0] s;
		for (int i = 0; i < TANH_DEPTH; i++) begin
			xr = (64'(i) << 15) >> TAB_AW;
			y = xr << 1;
			f = y & ((64'd1 << FRAC_BITS) - 64'd1);
			fq = f << (30 - FRAC_BITS);
			t = Q30_ONE;
			s = $signed(Q30_ONE);
			n = y >> FRAC_BITS;
			for (int j = 1; j <= 16; j++) begin
				t = udiv((t * fq) >> 30, 64'(j));
				if (j % 2 == 1)
					s = s - $signed(t);
				else
					s = s + $signed(t);
			end
			e = (s < 0) ? 64'd0 : 64'(s);
			if (e > Q30_ONE)
				e = Q30_ONE;
			for (int k = 0; k < 16; k++) begin
				if (64'(k) < n)
					e = (e * Q30_EXP_M1) >> 30;
			end
			num = ((Q30_ONE - e) << FRAC_BITS) + ((Q30_ONE + e) >> 1);
			den = Q30_ONE + e;
			tab[i] = TAB_W'(udiv(num, den));
		end
		return tab;
	endfunction

	localparam tab_t TANH_TAB = build_tanh();

endpackage

FILE: rtl/core/tnb_ctrl.sv
// controller state machine of the tanh neuron backprop unit
// sequences datapath commands per item; uses tnb_pkg
module tnb_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [1:0]     in_func,
	input  logic           in_last,
	input  tnb_pkg::stat_t stat,
	output tnb_pkg::ctl_t  ctl
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_MUL1, ST_ACC, ST_NET, ST_SQ, ST_DER,
		ST_MUL2, ST_MLR, ST_MOM, ST_SUM, ST_DONE
	} state_t;

	state_t state_q;
	tnb_pkg::func_t func_q;
	logic last_q;

	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			func_q <= tnb_pkg::FUNC_FWD;
			last_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						func_q <= tnb_pkg::func_t'(in_func);
						last_q <= in_last;
						state_q <= (tnb_pkg::func_t'(in_func) == tnb_pkg::FUNC_OGRAD)
							? ST_SQ : ST_MUL1;
					end
				end
				ST_MUL1: state_q <= (func_q == tnb_pkg::FUNC_UPD) ? ST_MLR : ST_ACC;
				ST_ACC: begin
					if (!last_q)
						state_q <= ST_IDLE;
					else
						state_q <= (func_q == tnb_pkg::FUNC_FWD) ? ST_NET : ST_SQ;
				end
				ST_NET: state_q <= ST_DONE;
				ST_SQ: state_q <= ST_DER;
				ST_DER: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_DONE;
				ST_MLR: state_q <= ST_MOM;
				ST_MOM: state_q <= ST_SUM;
				ST_SUM: state_q <= ST_DONE;
				ST_DONE: begin
					if (stat.out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		ctl.cmd = tnb_pkg::CMD_NONE;
		case (state_q)
			ST_IDLE: if (in_valid) ctl.cmd = tnb_pkg::CMD_LOAD;
			ST_MUL1: begin
				case (func_q)
					tnb_pkg::FUNC_FWD:   ctl.cmd = tnb_pkg::CMD_MUL_AW;
					tnb_pkg::FUNC_HGRAD: ctl.cmd = tnb_pkg::CMD_MUL_WG;
					default:             ctl.cmd = tnb_pkg::CMD_MUL_AG;
				endcase
			end
			ST_ACC: ctl.cmd = tnb_pkg::CMD_ACC;
			ST_NET: ctl.cmd = tnb_pkg::CMD_NET;
			ST_SQ: ctl.cmd = tnb_pkg::CMD_SQ;
			ST_DER: ctl.cmd = tnb_pkg::CMD_DER;
			ST_MUL2: ctl.cmd = (func_q == tnb_pkg::FUNC_OGRAD)
				? tnb_pkg::CMD_MUL_TD : tnb_pkg::CMD_MUL_AD;
			ST_MLR: ctl.cmd = tnb_pkg::CMD_MLR;
			ST_MOM: ctl.cmd = tnb_pkg::CMD_MOM;
			ST_SUM: ctl.cmd = tnb_pkg::CMD_SUM;
			ST_DONE: begin
				if (stat.out_free) begin
					case (func_q)
						tnb_pkg::FUNC_FWD:   ctl.cmd = tnb_pkg::CMD_OUT_FWD;
						tnb_pkg::FUNC_OGRAD: ctl.cmd = tnb_pkg::CMD_OUT_G1;
						tnb_pkg::FUNC_HGRAD: ctl.cmd = tnb_pkg::CMD_OUT_G2;
						default:             ctl.cmd = tnb_pkg::CMD_OUT_UPD;
					endcase
				end
			end
			default: ctl.cmd = tnb_pkg::CMD_NONE;
		endcase
	end

endmodule

FILE: rtl/core/tnb_dpath.sv
// datapath of the tanh neuron backprop unit: shared multiplier,
// accumulator, neuron state and result register; uses tnb_pkg
module tnb_dpath (
	input  logic               clk,
	input  logic               arst_n,
	input  tnb_pkg::ctl_t      ctl,
	output tnb_pkg::stat_t     stat,
	input  logic [79:0]        in_data,
	input  logic [15:0]        learning_rate,
	input  logic [15:0]        momentum,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [63:0]        out_data
);

	localparam logic signed [63:0] HALF_F = 64'sd1 <<< (tnb_pkg::FRAC_BITS - 1);
	localparam logic signed [63:0] HALF_2F = 64'sd1 <<< (2 * tnb_pkg::FRAC_BITS - 1);
	localparam logic signed [63:0] HALF_U = 64'sd1 <<< (tnb_pkg::FRAC_BITS + 15);
	localparam logic [16:0] IDX_MAX = 17'(tnb_pkg::TANH_DEPTH - 1);

	logic signed [15:0] act_q, wgt_q, ngr_q, tgt_q, old_q;
	logic signed [tnb_pkg::PROD_W-1:0] prod_q, t1_q;
	logic signed [tnb_pkg::ACC_W-1:0] acc_q;
	logic signed [13:0] out_q;
	logic signed [15:0] grad_q, nd_q;
	logic [tnb_pkg::FRAC_BITS:0] d_q;
	logic [tnb_pkg::TAB_AW-1:0] idx_q;
	logic neg_q;

	logic valid_q;
	logic signed [13:0] res_ov_q;
	logic signed [15:0] res_g_q, res_nw_q, res_nd_q;

	logic signed [tnb_pkg::MUL_AW-1:0] mul_a;
	logic signed [tnb_pkg::MUL_BW-1:0] mul_b;
	logic signed [tnb_pkg::PROD_W-1:0] mul_p;
	logic signed [tnb_pkg::ACC_W:0] acc_sum;
	logic signed [15:0] net_w;
	logic [16:0] abs_w, idx_w;
	logic signed [13:0] tab_v;
	logic [16:0] sq_rnd;
	logic signed [63:0] upd_sum;
	logic commit;

	assign stat.out_free = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data = {2'b00, res_nd_q, res_nw_q, res_g_q, res_ov_q};
	assign commit = ctl.cmd inside {tnb_pkg::CMD_OUT_FWD, tnb_pkg::CMD_OUT_G1,
		tnb_pkg::CMD_OUT_G2, tnb_pkg::CMD_OUT_UPD};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (ctl.cmd)
			tnb_pkg::CMD_MUL_AW: begin
				mul_a = tnb_pkg::MUL_AW'(act_q);
				mul_b = tnb_pkg::MUL_BW'(wgt_q);
			end
			tnb_pkg::CMD_MUL_WG: begin
				mul_a = tnb_pkg::MUL_AW'(wgt_q);
				mul_b = tnb_pkg::MUL_BW'(ngr_q);
			end
			tnb_pkg::CMD_MUL_AG: begin
				mul_a = tnb_pkg::MUL_AW'(act_q);
				mul_b = tnb_pkg::MUL_BW'(grad_q);
			end
			tnb_pkg::CMD_SQ: begin
				mul_a = tnb_pkg::MUL_AW'(out_q);
				mul_b = tnb_pkg::MUL_BW'(out_q);
			end
			tnb_pkg::CMD_MUL_TD: begin
				mul_a = tnb_pkg::MUL_AW'(tgt_q) - tnb_pkg::MUL_AW'(out_q);
				mul_b = $signed({{(tnb_pkg::MUL_BW - tnb_pkg::FRAC_BITS - 1){1'b0}}, d_q});
			end
			tnb_pkg::CMD_MUL_AD: begin
				mul_a = tnb_pkg::MUL_AW'(acc_q);
				mul_b = $signed({{(tnb_pkg::MUL_BW - tnb_pkg::FRAC_BITS - 1){1'b0}}, d_q});
			end
			tnb_pkg::CMD_MLR: begin
				mul_a = tnb_pkg::MUL_AW'($signed(prod_q[31:0]));
				mul_b = $signed({2'b00, learning_rate});
			end
			tnb_pkg::CMD_MOM: begin
				mul_a = tnb_pkg::MUL_AW'(old_q);
				mul_b = $signed({2'b00, momentum});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = tnb_pkg::PROD_W'(mul_a) * tnb_pkg::PROD_W'(mul_b);

	assign acc_sum = (tnb_pkg::ACC_W + 1)'(acc_q)
		+ (tnb_pkg::ACC_W + 1)'($signed(prod_q[31:0]));
	assign net_w = tnb_pkg::sat16((64'(acc_q) + HALF_F) >>> tnb_pkg::FRAC_BITS);
	assign abs_w = net_w[15] ? 17'(-(17'(net_w))) : 17'(net_w);
	assign idx_w = abs_w >> (15 - tnb_pkg::TAB_AW);
	assign tab_v = $signed({1'b0, tnb_pkg::TANH_TAB[idx_q]});
	assign sq_rnd = 17'((29'(prod_q[27:0]) + 29'(HALF_F)) >> tnb_pkg::FRAC_BITS);
	assign upd_sum = 64'(t1_q) + (64'(prod_q) <<< tnb_pkg::FRAC_BITS);

	always_ff @(posedge clk) begin
		case (ctl.cmd)
			tnb_pkg::CMD_LOAD: begin
				act_q <= in_data[15:0];
				wgt_q <= in_data[31:16];
				ngr_q <= in_data[47:32];
				tgt_q <= in_data[63:48];
				old_q <= in_data[79:64];
			end
			tnb_pkg::CMD_MUL_AW, tnb_pkg::CMD_MUL_WG, tnb_pkg::CMD_MUL_AG,
			tnb_pkg::CMD_SQ, tnb_pkg::CMD_MUL_TD, tnb_pkg::CMD_MUL_AD,
			tnb_pkg::CMD_MLR: prod_q <= mul_p;
			tnb_pkg::CMD_MOM: begin
				t1_q <= prod_q;
				prod_q <= mul_p;
			end
			tnb_pkg::CMD_NET: begin
				neg_q <= net_w[15];
				idx_q <= (idx_w > IDX_MAX) ? IDX_MAX[tnb_pkg::TAB_AW-1:0]
					: idx_w[tnb_pkg::TAB_AW-1:0];
			end
			tnb_pkg::CMD_DER: d_q <= (tnb_pkg::FRAC_BITS + 1)'(
				(17'd1 << tnb_pkg::FRAC_BITS) - sq_rnd);
			tnb_pkg::CMD_SUM: nd_q <= tnb_pkg::sat16((upd_sum + HALF_U)
				>>> (tnb_pkg::FRAC_BITS + 16));
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			out_q <= '0;
			grad_q <= '0;
			valid_q <= 1'b0;
			res_ov_q <= '0;
			res_g_q <= '0;
			res_nw_q <= '0;
			res_nd_q <= '0;
		end else begin
			if (valid_q && out_ready && !commit)
				valid_q <= 1'b0;
			case (ctl.cmd)
				tnb_pkg::CMD_ACC: begin
					if (acc_sum[tnb_pkg::ACC_W] != acc_sum[tnb_pkg::ACC_W-1])
						acc_q <= acc_sum[tnb_pkg::ACC_W]
							? {1'b1, {(tnb_pkg::ACC_W-1){1'b0}}}
							: {1'b0, {(tnb_pkg::ACC_W-1){1'b1}}};
					else
						acc_q <= acc_sum[tnb_pkg::ACC_W-1:0];
				end
				tnb_pkg::CMD_OUT_FWD: begin
					out_q <= neg_q ? -tab_v : tab_v;
					acc_q <= '0;
					valid_q <= 1'b1;
					res_ov_q <= neg_q ? -tab_v : tab_v;
					res_g_q <= '0;
					res_nw_q <= '0;
					res_nd_q <= '0;
				end
				tnb_pkg::CMD_OUT_G1: begin
					grad_q <= tnb_pkg::sat16((64'(prod_q) + HALF_F) >>> tnb_pkg::FRAC_BITS);
					valid_q <= 1'b1;
					res_ov_q <= '0;
					res_g_q <= tnb_pkg::sat16((64'(prod_q) + HALF_F) >>> tnb_pkg::FRAC_BITS);
					res_nw_q <= '0;
					res_nd_q <= '0;
				end
				tnb_pkg::CMD_OUT_G2: begin
					grad_q <= tnb_pkg::sat16((64'(prod_q) + HALF_2F)
						>>> (2 * tnb_pkg::FRAC_BITS));
					acc_q <= '0;
					valid_q <= 1'b1;
					res_ov_q <= '0;
					res_g_q <= tnb_pkg::sat16((64'(prod_q) + HALF_2F)
						>>> (2 * tnb_pkg::FRAC_BITS));
					res_nw_q <= '0;
					res_nd_q <= '0;
				end
				tnb_pkg::CMD_OUT_UPD: begin
					valid_q <= 1'b1;
					res_ov_q <= '0;
					res_g_q <= '0;
					res_nw_q <= tnb_pkg::sat16(64'(wgt_q) + 64'(nd_q));
					res_nd_q <= nd_q;
				end
				default: ;
			endcase
		end
	end

endmodule

FILE: rtl/core/tanh_neuron_backprop_unit.sv
// top level of the tanh neuron backprop unit
// holds the configuration registers; instantiates tnb_ctrl and tnb_dpath
//
// one neuron of a tanh perceptron in signed Q3.12, trained by momentum sgd.
// input channel s_*: s_tuser carries func, s_tlast marks the last term of a
// forward or hidden-gradient sum, s_tdata the operands. result channel m_*:
// one item per forward end, gradient or weight update, none for a middle term.
// one item is worked on at a time on a single shared multiplier.
// the result sits in an output register; the next item is taken as soon as
// it is written, while it still waits. a stalled receiver holds the unit in
// its last step until the previous result is taken.
// reset clears accumulator, neuron output and gradient and loads the default
// learning rate and momentum. learning_rate at 0x0, momentum at 0x4 (apb).
module tanh_neuron_backprop_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // activation, weight, next_gradient, target, old_delta
	input  logic [1:0]  s_tuser,   // func
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // out_value, gradient, new_weight, new_delta, zero pad
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [15:0] lr_q, mom_q;
	tnb_pkg::ctl_t ctl;
	tnb_pkg::stat_t stat;
	tnb_pkg::reg_idx_t reg_idx;

	assign pready = 1'b1;
	assign reg_idx = tnb_pkg::reg_idx_t'({1'b0, paddr[2]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q <= 16'd9830;
			mom_q <= 16'd32768;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				tnb_pkg::REG_LEARNING_RATE: lr_q <= pwdata[15:0];
				tnb_pkg::REG_MOMENTUM:      mom_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			tnb_pkg::REG_LEARNING_RATE: prdata = {16'd0, lr_q};
			tnb_pkg::REG_MOMENTUM:      prdata = {16'd0, mom_q};
			default:                    prdata = '0;
		endcase
	end

	tnb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_func  (s_tuser),
		.in_last  (s_tlast),
		.stat     (stat),
		.ctl      (ctl)
	);

	tnb_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.stat          (stat),
		.in_data       (s_tdata),
		.learning_rate (lr_q),
		.momentum      (mom_q),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_data      (m_tdata)
	);

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.cmd == tnb_pkg::CMD_OUT_FWD || ctl.cmd == tnb_pkg::CMD_OUT_G1 ||
		 ctl.cmd == tnb_pkg::CMD_OUT_G2 || ctl.cmd == tnb_pkg::CMD_OUT_UPD)
		|-> (!m_tvalid || m_tready))
		else $error("result written over a pending item");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second item taken while one is in work");

	a_load_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.cmd == tnb_pkg::CMD_LOAD) |-> (s_tvalid && s_tready))
		else $error("operands loaded without an accepted item");

endmodule

FILE: dv/tb.sv
// self-checking testbench of tanh_neuron_backprop_unit: random and directed items on s_*,
// results on m_* checked field by field against an internal fixed-point neuron model
// depends on rtl/core/tnb_pkg.sv and rtl/core/tanh_neuron_backprop_unit.sv
module tb;

	typedef struct {
		tnb_pkg::func_t    fn;
		bit                last;
		logic signed [15:0] act, wgt, ngr, tgt, old;
	} term_t;

	typedef struct {
		logic [13:0] ov;
		logic [15:0] gr, nw, nd;
	} result_t;

	localparam longint ACC_HI = 64'sd549755813887;
	localparam longint ACC_LO = -64'sd549755813888;
	localparam longint ONE30 = 64'd1 << 30;
	localparam longint EXPM1 = 64'd395007543;
	localparam int IDLE_LIMIT = 5000;

	logic        clk, arst_n;
	logic        s_tvalid, s_tready, s_tlast;
	logic [79:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid, m_tready;
	logic [63:0] m_tdata;
	logic        psel, penable, pwrite, pready;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;

	term_t   pending_terms[$];
	result_t expected_results[$];
	int      tanh_lut[256];
	longint  acc_sum;
	int      neuron_out, neuron_grad;
	int      eta, alpha;
	int      mismatches, tx_gap_mode, rx_gap_mode, tx_gap, rx_gap, hold_cnt;
	int      results_seen, idle_cycles;
	bit      hold_done;

	tanh_neuron_backprop_unit DUT (.*);

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	function automatic void build_lut();
		longint unsigned xr, y, f, fq, t, e, n;
		longint s;
		for (int i = 0; i < 256; i++) begin
			xr = (longint'(i) << 15) / 256;
			y = 2 * xr;
			f = y & 64'hfff;
			fq = f << 18;
			t = ONE30;
			s = ONE30;
			n = y >> 12;
			for (int j = 1; j <= 16; j++) begin
				t = ((t * fq) >> 30) / j;
				if (j % 2 == 1)
					s = s - longint'(t);
				else
					s = s + longint'(t);
			end
			e = (s < 0) ? 0 : s;
			if (e > ONE30)
				e = ONE30;
			for (longint unsigned k = 0; k < n && e != 0; k++)
				e = (e * EXPM1) >> 30;
			tanh_lut[i] = int'((((ONE30 - e) << 12) + (ONE30 + e) / 2) / (ONE30 + e));
		end
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint round_shift(longint v, int sh);
		return (v + (64'sd1 <<< (sh - 1))) >>> sh;
	endfunction

	function automatic longint slope();
		return 4096 - round_shift(longint'(neuron_out) * neuron_out, 12);
	endfunction

	function automatic void neuron_step(term_t it);
		result_t r;
		longint  nd, nw, net, a, idx;
		r = '{default: '0};
		case (it.fn)
			tnb_pkg::FUNC_FWD: begin
				acc_sum = clip(acc_sum + longint'(it.act) * it.wgt, ACC_LO, ACC_HI);
				if (!it.last)
					return;
				net = clip(round_shift(acc_sum, 12), -32768, 32767);
				a = net < 0 ? -net : net;
				idx = (a * 256) >> 15;
				if (idx > 255)
					idx = 255;
				neuron_out = net < 0 ? -tanh_lut[idx] : tanh_lut[idx];
				acc_sum = 0;
				r.ov = neuron_out[13:0];
			end
			tnb_pkg::FUNC_OGRAD: begin
				neuron_grad = int'(clip(round_shift((longint'(it.tgt) - neuron_out) * slope(), 12),
					-32768, 32767));
				r.gr = neuron_grad[15:0];
			end
			tnb_pkg::FUNC_HGRAD: begin
				acc_sum = clip(acc_sum + longint'(it.wgt) * it.ngr, ACC_LO, ACC_HI);
				if (!it.last)
					return;
				neuron_grad = int'(clip(round_shift(acc_sum * slope(), 24), -32768, 32767));
				acc_sum = 0;
				r.gr = neuron_grad[15:0];
			end
			default: begin
				nd = clip(round_shift(longint'(it.act) * neuron_grad * eta
					+ longint'(it.old) * alpha * 4096, 28), -32768, 32767);
				nw = clip(longint'(it.wgt) + nd, -32768, 32767);
				r.nd = nd[15:0];
				r.nw = nw[15:0];
			end
		endcase
		expected_results.insert(expected_results.size(), r);
	endfunction

	function automatic int draw_gap(int mode);
		int p;
		if (mode == 0)
			return 0;
		p = $urandom_range(99);
		if (p < 60)
			return 0;
		if (p < 94)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic signed [15:0] rand_val();
		case ($urandom_range(5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2, 3: return 16'($urandom);
			default: return 16'($signed($urandom_range(0, 8191)) - 4096);
		endcase
	endfunction

	function automatic void add_term(tnb_pkg::func_t fn, bit last, logic signed [15:0] act,
		logic signed [15:0] wgt, logic signed [15:0] ngr, logic signed [15:0] tgt,
		logic signed [15:0] old);
		term_t it;
		it.fn = fn; it.last = last; it.act = act; it.wgt = wgt;
		it.ngr = ngr; it.tgt = tgt; it.old = old;
		pending_terms.insert(pending_terms.size(), it);
	endfunction

	function automatic void add_rand(tnb_pkg::func_t fn, bit last);
		add_term(fn, last, rand_val(), rand_val(), rand_val(), rand_val(), rand_val());
	endfunction

	function automatic void add_training_pass();
		int n;
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++)
			add_rand(tnb_pkg::FUNC_FWD, i == n - 1);
		if ($urandom_range(1))
			add_rand(tnb_pkg::FUNC_OGRAD, $urandom_range(1));
		else begin
			n = $urandom_range(1, 5);
			for (int i = 0; i < n; i++)
				add_rand(tnb_pkg::FUNC_HGRAD, i == n - 1);
		end
		n = $urandom_range(1, 4);
		for (int i = 0; i < n; i++)
			add_rand(tnb_pkg::FUNC_UPD, $urandom_range(1));
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		term_t it;
		int    gap;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			s_tlast <= 1'b0;
			tx_gap <= 0;
		end else begin
			gap = tx_gap;
			if (s_tvalid && s_tready)
				neuron_step('{tnb_pkg::func_t'(s_tuser), s_tlast, s_tdata[15:0],
					s_tdata[31:16], s_tdata[47:32], s_tdata[63:48], s_tdata[79:64]});
			if (!s_tvalid || s_tready) begin
				if (gap > 0) begin
					s_tvalid <= 1'b0;
					gap--;
				end else if (pending_terms.size() > 0) begin
					it = pending_terms.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= it.fn;
					s_tlast <= it.last;
					s_tdata <= {it.old, it.tgt, it.ngr, it.wgt, it.act};
					gap = draw_gap(tx_gap_mode);
				end else
					s_tvalid <= 1'b0;
			end
			tx_gap <= gap;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		result_t r;
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_gap <= 0;
			hold_cnt <= 0;
			hold_done <= 1'b0;
			results_seen <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen <= results_seen + 1;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected item %h", m_tdata);
				end else begin
					r = expected_results.pop_front();
					if (m_tdata[13:0] !== r.ov || m_tdata[29:14] !== r.gr ||
						m_tdata[45:30] !== r.nw || m_tdata[61:46] !== r.nd) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp ov %h gr %h nw %h nd %h, got %h %h %h %h",
								r.ov, r.gr, r.nw, r.nd, m_tdata[13:0], m_tdata[29:14],
								m_tdata[45:30], m_tdata[61:46]);
					end
				end
			end
			if (!hold_done && results_seen == 20) begin
				hold_done <= 1'b1;
				hold_cnt <= 200;
				m_tready <= 1'b0;
			end else if (hold_cnt > 0) begin
				hold_cnt <= hold_cnt - 1;
				m_tready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap <= rx_gap - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				rx_gap <= draw_gap(rx_gap_mode);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel || !arst_n)
			idle_cycles <= 0;
		else if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	task automatic reg_write(tnb_pkg::reg_idx_t idx, logic [15:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx[0], 2'b00}; pwdata <= {16'($urandom), val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0;
		if (idx == tnb_pkg::REG_LEARNING_RATE)
			eta = val;
		else
			alpha = val;
	endtask

	task automatic drain();
		while (pending_terms.size() > 0 || s_tvalid || expected_results.size() > 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	initial begin
		logic [15:0] lr_set[4];
		logic [15:0] mom_set[4];
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		mismatches = 0; idle_cycles = 0;
		tx_gap_mode = 0; rx_gap_mode = 0;
		build_lut();
		acc_sum = 0; neuron_out = 0; neuron_grad = 0;
		eta = 9830; alpha = 32768;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset register values
		add_term(tnb_pkg::FUNC_OGRAD, 1'b1, 0, 0, 0, 16'sh7fff, 0);
		add_term(tnb_pkg::FUNC_HGRAD, 1'b0, 0, 16'sh7fff, 16'sh8000, 0, 0);
		add_term(tnb_pkg::FUNC_HGRAD, 1'b1, 0, 16'sh8000, 16'sh8000, 0, 0);
		add_term(tnb_pkg::FUNC_UPD, 1'b0, 16'sh7fff, 16'sh7fff, 0, 0, 16'sh7fff);
		add_term(tnb_pkg::FUNC_FWD, 1'b0, 16'sh7fff, 16'sh7fff, 0, 0, 0);
		add_term(tnb_pkg::FUNC_FWD, 1'b1, 16'sh8000, 16'sh7fff, 0, 0, 0);
		add_term(tnb_pkg::FUNC_FWD, 1'b1, 16'sh0800, 16'sh1000, 0, 0, 0);
		add_term(tnb_pkg::FUNC_OGRAD, 1'b0, 0, 0, 0, 16'sh8000, 0);
		add_term(tnb_pkg::FUNC_OGRAD, 1'b1, 0, 0, 0, 16'sh7fff, 0);
		add_term(tnb_pkg::FUNC_UPD, 1'b1, 16'sh8000, 16'sh8000, 0, 0, 16'sh8000);
		add_term(tnb_pkg::FUNC_UPD, 1'b0, 16'sh7fff, 16'sh7fff, 0, 0, 16'sh7fff);
		add_term(tnb_pkg::FUNC_FWD, 1'b0, 16'sh0400, 16'sh0400, 0, 0, 0);
		add_term(tnb_pkg::FUNC_HGRAD, 1'b0, 0, 16'sh0300, 16'shf000, 0, 0);
		add_term(tnb_pkg::FUNC_HGRAD, 1'b1, 0, 16'sh0100, 16'sh0200, 0, 0);
		add_term(tnb_pkg::FUNC_FWD, 1'b1, 16'sh8000, 16'sh8000, 0, 0, 0);
		add_term(tnb_pkg::FUNC_FWD, 1'b1, 16'sh0000, 16'sh0000, 0, 0, 0);
		add_term(tnb_pkg::FUNC_HGRAD, 1'b1, 0, 16'sh0100, 16'sh0100, 0, 0);
		drain();

		lr_set = '{16'h0000, 16'hffff, 16'($urandom), 16'd9830};
		mom_set = '{16'h0000, 16'hffff, 16'($urandom), 16'd32768};
		for (int ph = 0; ph < 4; ph++) begin
			reg_write(tnb_pkg::REG_LEARNING_RATE, lr_set[ph]);
			reg_write(tnb_pkg::REG_MOMENTUM, mom_set[ph]);
			tx_gap_mode = (ph != 1);
			rx_gap_mode = (ph != 2);
			if (ph == 2) begin
				// accumulator saturation, both signs
				for (int i = 0; i < 516; i++)
					add_term(tnb_pkg::FUNC_FWD, i == 515, 16'sh8000, 16'sh8000, 0, 0, 0);
				for (int i = 0; i < 516; i++)
					add_term(tnb_pkg::FUNC_HGRAD, i == 515, 0, 16'sh7fff, 16'sh8000, 0, 0);
			end
			for (int k = 0; k < 6; k++) begin
				if ($urandom_range(9) == 0)
					add_rand(tnb_pkg::func_t'($urandom_range(3)), $urandom_range(1));
				else
					add_training_pass();
			end
			drain();
		end

		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
